FILE: hw/rtl/tea_pkg.sv
// Package with the shared types, register codes and round function of the TEA block.
`timescale 1ns / 1ps

package tea_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_A  = 3'd0,
    REG_KEY_B  = 3'd1,
    REG_KEY_C  = 3'd2,
    REG_KEY_D  = 3'd3,
    REG_DELTA  = 3'd4
  } cfg_reg_e;

  localparam word_t DeltaReset = 32'h9E37_79B9;

  // Words carried from one half-round cell to the next. The word in y is
  // mixed and added into x, then the two swap places.
  typedef struct packed {
    word_t x;
    word_t y;
    word_t sum;
  } cell_data_t;

  typedef struct packed {
    word_t ka;
    word_t kb;
  } key_pair_t;

  function automatic word_t tea_mix(word_t y, word_t sum, key_pair_t keys);
    word_t shl;
    word_t shr;
    shl = {y[WordW-5:0], 4'b0000};
    shr = {5'b00000, y[WordW-1:5]};
    return (shl + keys.ka) ^ (y + sum) ^ (shr + keys.kb);
  endfunction

endpackage

FILE: hw/rtl/tea_ifs.sv
// Channel interfaces of the TEA block: plaintext input, ciphertext output and configuration.
`timescale 1ns / 1ps

interface tea_in_if;
  logic                  valid;
  logic                  ready;
  logic [31:0]           plain_low;
  logic [31:0]           plain_high;

  modport source (output valid, plain_low, plain_high, input ready);
  modport sink   (input valid, plain_low, plain_high, output ready);
endinterface

interface tea_out_if;
  logic                  valid;
  logic                  ready;
  logic [31:0]           cipher_low;
  logic [31:0]           cipher_high;

  modport source (output valid, cipher_low, cipher_high, input ready);
  modport sink   (input valid, cipher_low, cipher_high, output ready);
endinterface

interface tea_cfg_if;
  logic                  valid;
  logic                  ready;
  logic [2:0]            index;
  logic [31:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/tea_round_cell.sv
// One half-round cell of the TEA chain: mixes one word into the other and swaps them.
`timescale 1ns / 1ps

module tea_round_cell #(
  parameter bit SecondHalf = 1'b0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  tea_pkg::cell_data_t data_i,
  input  tea_pkg::key_pair_t  keys_i,
  input  tea_pkg::word_t      delta_i,
  output logic                valid_o,
  output tea_pkg::cell_data_t data_o
);

  logic                valid_q;
  tea_pkg::cell_data_t data_d, data_q;

  // The second half of a round also advances the sum for the next round.
  always_comb begin
    data_d.x   = data_i.y;
    data_d.y   = data_i.x + tea_pkg::tea_mix(data_i.y, data_i.sum, keys_i);
    data_d.sum = SecondHalf ? (data_i.sum + delta_i) : data_i.sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hw/rtl/tea_block_encrypt_folded_key.sv
// Top level of the TEA block encryptor with a folded key: configuration and cell chain.
`timescale 1ns / 1ps

// TEA encryption of one 64-bit block per item, built as a chain of 2*ROUNDS
// half-round cells, each a register stage. A new item is accepted in every
// cycle while the output is taken; each item passes through all 2*ROUNDS
// cell registers in order before it leaves. When a finished item at the
// output is not taken, the whole chain holds. The four key words are
// folded into one word k0 by XOR; the other key words are k0 rotated left by
// 8, 16 and 24 bits. Configuration writes are accepted in every cycle and must
// only be made while no item is in flight; writes to unknown indexes are
// dropped.
module tea_block_encrypt_folded_key #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tea_cfg_if.sink      cfg_i,
  tea_in_if.sink       in_i,
  tea_out_if.source    out_o
);

  localparam int unsigned Cells = 2 * ROUNDS;

  tea_pkg::word_t key_a_q, key_b_q, key_c_q, key_d_q, delta_q;
  tea_pkg::word_t k0;
  tea_pkg::key_pair_t keys_first, keys_second;
  logic cfg_wr;
  logic en;

  logic                valid_chain [Cells+1];
  tea_pkg::cell_data_t data_chain  [Cells+1];
  logic [Cells-1:0]    valid_vec;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_a_q <= '0;
      key_b_q <= '0;
      key_c_q <= '0;
      key_d_q <= '0;
      delta_q <= tea_pkg::DeltaReset;
    end else if (cfg_wr) begin
      unique case (cfg_i.index)
        tea_pkg::REG_KEY_A: key_a_q <= cfg_i.data;
        tea_pkg::REG_KEY_B: key_b_q <= cfg_i.data;
        tea_pkg::REG_KEY_C: key_c_q <= cfg_i.data;
        tea_pkg::REG_KEY_D: key_d_q <= cfg_i.data;
        tea_pkg::REG_DELTA: delta_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign k0 = key_a_q ^ key_b_q ^ key_c_q ^ key_d_q;

  assign keys_first.ka  = k0;
  assign keys_first.kb  = {k0[23:0], k0[31:24]};
  assign keys_second.ka = {k0[15:0], k0[31:16]};
  assign keys_second.kb = {k0[7:0], k0[31:8]};

  // The chain moves whenever the last stage is empty or being taken.
  assign en         = !valid_chain[Cells] || out_o.ready;
  assign in_i.ready = en;

  assign valid_chain[0]    = in_i.valid;
  assign data_chain[0].x   = in_i.plain_low;
  assign data_chain[0].y   = in_i.plain_high;
  assign data_chain[0].sum = delta_q;

  for (genvar i = 0; i < Cells; i++) begin : g_cell
    localparam bit SecondHalf = ((i % 2) == 1);

    tea_round_cell #(
      .SecondHalf(SecondHalf)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_chain[i]),
      .data_i  (data_chain[i]),
      .keys_i  (SecondHalf ? keys_second : keys_first),
      .delta_i (delta_q),
      .valid_o (valid_chain[i+1]),
      .data_o  (data_chain[i+1])
    );

    assign valid_vec[i] = valid_chain[i+1];
  end

  assign out_o.valid       = valid_chain[Cells];
  assign out_o.cipher_low  = data_chain[Cells].x;
  assign out_o.cipher_high = data_chain[Cells].y;

  // A held chain keeps every stage's occupancy.
  a_hold_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(valid_vec))
    else $error("Chain occupancy changed while the output was stalled.");

  a_delta_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && (cfg_i.index == tea_pkg::REG_DELTA) |=> delta_q == $past(cfg_i.data))
    else $error("Delta register did not take the written value.");

  a_key_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && (cfg_i.index == tea_pkg::REG_KEY_A)
      |=> k0 == ($past(k0) ^ $past(key_a_q) ^ $past(cfg_i.data)))
    else $error("Folded key does not follow a key word write.");

  a_bad_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && (cfg_i.index != tea_pkg::REG_KEY_A) && (cfg_i.index != tea_pkg::REG_KEY_B)
      && (cfg_i.index != tea_pkg::REG_KEY_C) && (cfg_i.index != tea_pkg::REG_KEY_D)
      && (cfg_i.index != tea_pkg::REG_DELTA)
      |=> $stable(k0) && $stable(delta_q))
    else $error("Write to an unknown register index changed the configuration.");

endmodule

FILE: tb/tea_block_encrypt_folded_key_tb.sv
// Testbench for the folded-key TEA block encryptor, checked against an in-bench predictor.
`timescale 1ns / 1ps

module tea_block_encrypt_folded_key_tb;

  localparam int unsigned RoundCount = 32;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned CfgIdxW = tea_pkg::CfgIdxW;

  typedef struct packed {
    tea_pkg::word_t low;
    tea_pkg::word_t high;
  } tea_block_t;

  logic clk_i;
  logic rst_ni;

  tea_cfg_if cfg_if();
  tea_in_if  in_if();
  tea_out_if out_if();

  tea_block_encrypt_folded_key #(
    .ROUNDS(RoundCount)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  tea_pkg::word_t key_a;
  tea_pkg::word_t key_b;
  tea_pkg::word_t key_c;
  tea_pkg::word_t key_d;
  tea_pkg::word_t delta;

  tea_block_t  plain_q[$];
  tea_block_t  cipher_q[$];
  int unsigned issued_count;
  int unsigned checked_count;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned recv_draw;
  bit          no_idle;

  function automatic tea_block_t tea_encrypt_block(tea_pkg::word_t plain_low,
                                                   tea_pkg::word_t plain_high);
    tea_pkg::word_t k0;
    tea_pkg::word_t k1;
    tea_pkg::word_t k2;
    tea_pkg::word_t k3;
    tea_pkg::word_t v0;
    tea_pkg::word_t v1;
    tea_pkg::word_t sum;
    tea_block_t     res;
    k0  = key_a ^ key_b ^ key_c ^ key_d;
    k1  = {k0[23:0], k0[31:24]};
    k2  = {k0[15:0], k0[31:16]};
    k3  = {k0[7:0], k0[31:8]};
    v0  = plain_low;
    v1  = plain_high;
    sum = '0;
    for (int r = 0; r < RoundCount; r++) begin
      sum = sum + delta;
      v0  = v0 + (((v1 << 4) + k0) ^ (v1 + sum) ^ ((v1 >> 5) + k1));
      v1  = v1 + (((v0 << 4) + k2) ^ (v0 + sum) ^ ((v0 >> 5) + k3));
    end
    res.low  = v0;
    res.high = v1;
    return res;
  endfunction

  function automatic int unsigned idle_draw();
    return no_idle ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic tea_pkg::word_t pick_word();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_error(string msg);
    error_count++;
    if (error_count <= ReportLimit) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid      <= 1'b0;
      in_if.plain_low  <= '0;
      in_if.plain_high <= '0;
      send_gap         <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (send_gap != 0) begin
        in_if.valid <= 1'b0;
        send_gap    <= send_gap - 1;
      end else if (plain_q.size() != 0) begin
        in_if.valid      <= 1'b1;
        in_if.plain_low  <= plain_q[0].low;
        in_if.plain_high <= plain_q[0].high;
        plain_q.pop_front();
        send_gap         <= idle_draw();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready  <= 1'b0;
      recv_stall    <= 0;
      checked_count <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        cipher_q.push_back(tea_encrypt_block(in_if.plain_low, in_if.plain_high));
      end
      if (out_if.valid && out_if.ready) begin
        if (cipher_q.size() == 0) begin
          report_error($sformatf("unexpected cipher item %h_%h",
                                 out_if.cipher_high, out_if.cipher_low));
        end else begin
          if (out_if.cipher_low !== cipher_q[0].low) begin
            report_error($sformatf("cipher_low mismatch: expected %h, got %h",
                                   cipher_q[0].low, out_if.cipher_low));
          end
          if (out_if.cipher_high !== cipher_q[0].high) begin
            report_error($sformatf("cipher_high mismatch: expected %h, got %h",
                                   cipher_q[0].high, out_if.cipher_high));
          end
          cipher_q.pop_front();
        end
        checked_count <= checked_count + 1;
        recv_draw      = idle_draw();
        recv_stall    <= recv_draw;
        out_if.ready  <= (recv_draw == 0);
      end else if (recv_stall != 0) begin
        out_if.ready <= (recv_stall == 1);
        recv_stall   <= recv_stall - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, tea_pkg::word_t value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      tea_pkg::REG_KEY_A: key_a = value;
      tea_pkg::REG_KEY_B: key_b = value;
      tea_pkg::REG_KEY_C: key_c = value;
      tea_pkg::REG_KEY_D: key_d = value;
      tea_pkg::REG_DELTA: delta = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic queue_block(tea_pkg::word_t plain_low, tea_pkg::word_t plain_high);
    tea_block_t blk;
    blk.low  = plain_low;
    blk.high = plain_high;
    plain_q.push_back(blk);
    issued_count++;
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (checked_count != issued_count) @(posedge clk_i);
  endtask

  task automatic random_blocks(int unsigned count);
    @(negedge clk_i);
    repeat (count) queue_block($urandom, $urandom);
    wait_idle();
  endtask

  initial begin
    tea_pkg::word_t shared;
    rst_ni        = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    key_a         = '0;
    key_b         = '0;
    key_c         = '0;
    key_d         = '0;
    delta         = tea_pkg::DeltaReset;
    issued_count  = 0;
    error_count   = 0;
    cycle_count   = 0;
    no_idle       = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration with extreme and patterned plaintext.
    @(negedge clk_i);
    queue_block('0, '0);
    queue_block('1, '1);
    queue_block('0, '1);
    queue_block('1, '0);
    queue_block(32'h8000_0000, 32'h0000_0001);
    queue_block(32'h0000_0001, 32'h8000_0000);
    queue_block(32'hAAAA_AAAA, 32'h5555_5555);
    queue_block(32'h5555_5555, 32'hAAAA_AAAA);
    wait_idle();

    // All-ones folded key with a zero delta, so the sum never moves.
    write_reg(tea_pkg::REG_KEY_A, '1);
    write_reg(tea_pkg::REG_KEY_B, '0);
    write_reg(tea_pkg::REG_KEY_C, '0);
    write_reg(tea_pkg::REG_KEY_D, '0);
    write_reg(tea_pkg::REG_DELTA, '0);
    @(negedge clk_i);
    queue_block('0, '0);
    queue_block('1, '1);
    queue_block($urandom, $urandom);
    queue_block($urandom, $urandom);
    wait_idle();

    // Key words that cancel in the fold, with the largest delta.
    shared = $urandom;
    write_reg(tea_pkg::REG_KEY_A, shared);
    write_reg(tea_pkg::REG_KEY_B, shared);
    shared = $urandom;
    write_reg(tea_pkg::REG_KEY_C, shared);
    write_reg(tea_pkg::REG_KEY_D, shared);
    write_reg(tea_pkg::REG_DELTA, '1);
    @(negedge clk_i);
    queue_block('0, '1);
    queue_block('1, '0);
    queue_block($urandom, $urandom);
    queue_block($urandom, $urandom);
    wait_idle();

    // Writes to unused indexes must leave the configuration alone.
    for (int r = int'(tea_pkg::REG_DELTA) + 1; r < (1 << CfgIdxW); r++) begin
      write_reg(CfgIdxW'(r), '1);
    end
    @(negedge clk_i);
    queue_block('0, '0);
    queue_block($urandom, $urandom);
    queue_block('1, '1);
    wait_idle();

    for (int phase = 0; phase < 12; phase++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      for (int r = 0; r < (1 << CfgIdxW); r++) begin
        if ($urandom_range(0, 1) == 1) begin
          write_reg(CfgIdxW'(r), pick_word());
        end
      end
      random_blocks($urandom_range(80, 125));
    end

    wait_idle();
    repeat (2 * RoundCount + 16) @(posedge clk_i);
    error_count += cipher_q.size();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/tea_pkg.sv
hw/rtl/tea_ifs.sv
hw/rtl/tea_round_cell.sv
hw/rtl/tea_block_encrypt_folded_key.sv
tb/tea_block_encrypt_folded_key_tb.sv
